[sv/word_array_mix_hash64_defines.svh]
// ---------------------------------------------------------------------------
// word_array_mix_hash64 assertion macros
// shared concurrent assertion forms used by the hash block modules
// ---------------------------------------------------------------------------
`ifndef WORD_ARRAY_MIX_HASH64_DEFINES_SVH
`define WORD_ARRAY_MIX_HASH64_DEFINES_SVH

// same-cycle implication
`define WAMH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WAMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wamh64_pkg.sv]
// ---------------------------------------------------------------------------
// wamh64_pkg
// types, constants and mix round functions of the 64-bit word array hash
// ---------------------------------------------------------------------------
package wamh64_pkg;

  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c13;

  localparam logic OP_START = 1'b0;
  localparam logic OP_WORD  = 1'b1;

  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_AW         = 2;
  localparam int ROUNDS_PER_PHASE = 4;
  localparam int MIX_ROUNDS       = 12;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_ZERO,
    CMD_ADD_C,
    CMD_ADD_B,
    CMD_ADD_A_MIX
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        last;
    logic [63:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    SLOT_GROUP,
    SLOT_B,
    SLOT_A
  } slot_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_RUN1,
    MS_RUN2
  } mix_state_t;

  typedef enum logic [1:0] {
    ROLE_A,
    ROLE_B,
    ROLE_C
  } mix_role_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } abc_t;

  localparam logic [5:0] ROUND_SHIFT [0:MIX_ROUNDS-1] = '{
    6'd43, 6'd9,  6'd8,
    6'd38, 6'd23, 6'd5,
    6'd35, 6'd49, 6'd11,
    6'd12, 6'd18, 6'd22
  };

  localparam mix_role_t ROUND_ROLE [0:MIX_ROUNDS-1] = '{
    ROLE_A, ROLE_B, ROLE_C,
    ROLE_A, ROLE_B, ROLE_C,
    ROLE_A, ROLE_B, ROLE_C,
    ROLE_A, ROLE_B, ROLE_C
  };

  // one subtract/xor/shift round
  function automatic abc_t mix_round(abc_t s, logic [3:0] idx);
    abc_t r;
    r = s;
    unique case (ROUND_ROLE[idx])
      ROLE_A: begin
        r.a = s.a - s.b - s.c;
        r.a = r.a ^ (s.c >> ROUND_SHIFT[idx]);
      end
      ROLE_B: begin
        r.b = s.b - s.c - s.a;
        r.b = r.b ^ (s.a << ROUND_SHIFT[idx]);
      end
      ROLE_C: begin
        r.c = s.c - s.a - s.b;
        r.c = r.c ^ (s.b >> ROUND_SHIFT[idx]);
      end
      default: r = s;
    endcase
    return r;
  endfunction

  // four consecutive rounds starting at a fixed round index
  function automatic abc_t mix_phase(abc_t s, logic [3:0] base);
    abc_t r;
    r = s;
    for (int k = 0; k < ROUNDS_PER_PHASE; k++) begin
      r = mix_round(r, base + 4'(k));
    end
    return r;
  endfunction

endpackage

[sv/wamh64_front.sv]
// ---------------------------------------------------------------------------
// wamh64_front
// accepts items, tracks words left and group slot, issues commands
// ---------------------------------------------------------------------------
`include "word_array_mix_hash64_defines.svh"

module wamh64_front #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [63:0]        in_data_word,
  input  logic [31:0]        in_word_count,
  output logic               push,
  output wamh64_pkg::cmd_t   push_cmd,
  input  logic               q_full
);
  import wamh64_pkg::*;

  logic [COUNT_BITS-1:0] words_left_r, words_left_nxt;
  slot_t                 slot_r, slot_nxt;
  logic [63:0]           count_wide;
  logic [COUNT_BITS-1:0] count_in;
  logic                  accept;
  logic                  has_words;

  assign count_wide = 64'(in_word_count);
  assign count_in   = count_wide[COUNT_BITS-1:0];
  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign has_words  = words_left_r != '0;

  // classify the item
  always_comb begin
    push          = 1'b0;
    push_cmd.kind = CMD_START;
    push_cmd.last = 1'b0;
    push_cmd.data = in_data_word;
    if (in_opcode == OP_START) begin
      push          = accept;
      push_cmd.data = 64'(count_in);
      push_cmd.kind = (count_in == '0) ? CMD_ZERO : CMD_START;
    end else if (has_words) begin
      push          = accept;
      push_cmd.last = words_left_r == COUNT_BITS'(1);
      unique case (slot_r)
        SLOT_GROUP: begin
          if (words_left_r >= COUNT_BITS'(3)) begin
            push_cmd.kind = CMD_ADD_C;
          end else if (words_left_r == COUNT_BITS'(2)) begin
            push_cmd.kind = CMD_ADD_B;
          end else begin
            push_cmd.kind = CMD_ADD_A_MIX;
          end
        end
        SLOT_B:  push_cmd.kind = CMD_ADD_B;
        SLOT_A:  push_cmd.kind = CMD_ADD_A_MIX;
        default: push_cmd.kind = CMD_ADD_A_MIX;
      endcase
    end
  end

  // next slot and count
  always_comb begin
    slot_nxt       = slot_r;
    words_left_nxt = words_left_r;
    if (accept) begin
      if (in_opcode == OP_START) begin
        slot_nxt       = SLOT_GROUP;
        words_left_nxt = count_in;
      end else if (has_words) begin
        words_left_nxt = words_left_r - COUNT_BITS'(1);
        case (push_cmd.kind)
          CMD_ADD_C: slot_nxt = SLOT_B;
          CMD_ADD_B: slot_nxt = SLOT_A;
          default:   slot_nxt = SLOT_GROUP;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r       <= SLOT_GROUP;
      words_left_r <= '0;
    end else begin
      slot_r       <= slot_nxt;
      words_left_r <= words_left_nxt;
    end
  end

  `WAMH_ASSERT_IMPL(a_last_word_mixes, clk, rst_n, push && push_cmd.last, push_cmd.kind == CMD_ADD_A_MIX, "last word of a hash does not end in a mix")

endmodule

[sv/wamh64_queue.sv]
// ---------------------------------------------------------------------------
// wamh64_queue
// short command queue between the front and the mix engine
// ---------------------------------------------------------------------------
`include "word_array_mix_hash64_defines.svh"

module wamh64_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wamh64_pkg::cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output wamh64_pkg::cmd_t head,
  output logic             head_valid
);
  import wamh64_pkg::*;

  cmd_t                entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign full       = count_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QUEUE_AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `WAMH_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "command pushed into a full queue")
  `WAMH_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head_valid, "command popped from an empty queue")

endmodule

[sv/wamh64_back.sv]
// ---------------------------------------------------------------------------
// wamh64_back
// accumulator state, mix engine and result register
// ---------------------------------------------------------------------------
`include "word_array_mix_hash64_defines.svh"

module wamh64_back (
  input  logic             clk,
  input  logic             rst_n,
  input  wamh64_pkg::cmd_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      out_hash_value
);
  import wamh64_pkg::*;

  mix_state_t  state_r, state_nxt;
  abc_t        abc_r, abc_nxt;
  abc_t        abc_in;
  logic [63:0] pend_c_r, pend_c_nxt;
  logic [63:0] pend_b_r, pend_b_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;
  logic        out_free;
  logic        out_load;
  logic        mix_go;
  logic        mix_adv;

  assign out_free       = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  always_comb begin
    abc_in.a = abc_r.a + head.data;
    abc_in.b = abc_r.b + pend_b_r;
    abc_in.c = abc_r.c + pend_c_r;
  end

  // datapath and handshake controls
  always_comb begin
    pop          = 1'b0;
    mix_go       = 1'b0;
    mix_adv      = 1'b0;
    out_load     = 1'b0;
    abc_nxt      = abc_r;
    pend_c_nxt   = pend_c_r;
    pend_b_nxt   = pend_b_r;
    last_nxt     = last_r;
    out_hash_nxt = out_hash_r;

    // next group words are staged in any state
    if (head_valid) begin
      case (head.kind)
        CMD_ADD_C: begin
          pop        = 1'b1;
          pend_c_nxt = head.data;
        end
        CMD_ADD_B: begin
          pop        = 1'b1;
          pend_b_nxt = head.data;
        end
        default: ;
      endcase
    end

    unique case (state_r)
      MS_IDLE: begin
        if (head_valid) begin
          case (head.kind)
            CMD_START: begin
              pop        = 1'b1;
              abc_nxt.a  = GOLDEN;
              abc_nxt.b  = GOLDEN;
              abc_nxt.c  = head.data;
              pend_c_nxt = '0;
              pend_b_nxt = '0;
            end
            CMD_ZERO: begin
              if (out_free) begin
                pop          = 1'b1;
                out_load     = 1'b1;
                out_hash_nxt = '0;
              end
            end
            CMD_ADD_A_MIX: begin
              pop        = 1'b1;
              mix_go     = 1'b1;
              abc_nxt    = mix_phase(abc_in, 4'd0);
              pend_c_nxt = '0;
              pend_b_nxt = '0;
              last_nxt   = head.last;
            end
            default: ;
          endcase
        end
      end
      MS_RUN1: begin
        abc_nxt = mix_phase(abc_r, 4'(ROUNDS_PER_PHASE));
      end
      MS_RUN2: begin
        if (!last_r || out_free) begin
          mix_adv = 1'b1;
          abc_nxt = mix_phase(abc_r, 4'(2 * ROUNDS_PER_PHASE));
          if (last_r) begin
            out_load     = 1'b1;
            out_hash_nxt = abc_nxt.c;
          end
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  // mix engine sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MS_IDLE: if (mix_go) state_nxt = MS_RUN1;
      MS_RUN1: state_nxt = MS_RUN2;
      MS_RUN2: if (mix_adv) state_nxt = MS_IDLE;
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    abc_r      <= abc_nxt;
    pend_c_r   <= pend_c_nxt;
    pend_b_r   <= pend_b_nxt;
    out_hash_r <= out_hash_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= MS_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `WAMH_ASSERT_NEXT(a_run1_to_run2, clk, rst_n, state_r == MS_RUN1, state_r == MS_RUN2, "mix engine left the second phase out")
  `WAMH_ASSERT_IMPL(a_result_is_last, clk, rst_n, out_load && state_r == MS_RUN2, last_r, "mix result given for a hash that is not finished")

endmodule

[sv/word_array_mix_hash64.sv]
// ---------------------------------------------------------------------------
// word_array_mix_hash64
// 64-bit hash of a word array with a three-accumulator subtract/xor mix
// ---------------------------------------------------------------------------
// in_ channel: a start item (in_opcode 0) carries in_word_count; data items
//   (in_opcode 1) carry in_data_word, highest array index first. Data items
//   with no hash in progress are dropped; a start abandons any open hash.
// out_ channel: one out_hash_value per hash, after its last word, or right
//   after a start with a count of zero (value 0).
// Throughput: one word per cycle across full groups of three while in_stall
//   is low. The front classifies each word and queues it; the back stages
//   the first two words of a group and runs the 12-round mix in phases of
//   four rounds each, overlapping the staging of the next group's words.
//   A start or a tail mix right behind a mix waits in the queue for MS_IDLE.
// Result: the last word passes the queue, the mix phases of MS_IDLE, MS_RUN1
//   and MS_RUN2 and the result register; a zero-count start skips the mix.
// Stall: out_stall holds the result register; the mix engine then waits in
//   its last phase, the 4-entry queue fills and in_stall rises.
// Reset: synchronous rst_n empties the queue, idles the mix engine, drops
//   any open hash and clears out_valid.
// ---------------------------------------------------------------------------
module word_array_mix_hash64 #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [63:0] in_data_word,
  input  logic [31:0] in_word_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);
  import wamh64_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t head;
  logic head_valid;

  wamh64_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_data_word  (in_data_word),
    .in_word_count (in_word_count),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  wamh64_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  wamh64_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the 64-bit word array hash: directed and random
// starts, word streams, restarts and stray words, with random gaps on the
// input side and random holds on the result side; each hash is predicted
// in the bench and compared with the block's result in order
// ---------------------------------------------------------------------------
module tb_top;
  import wamh64_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned RANDOM_ITEMS = 1400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [63:0] in_data_word;
  logic [31:0] in_word_count;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_hash_value;

  word_array_mix_hash64 u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_data_word  (in_data_word),
    .in_word_count (in_word_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value)
  );

  // bench copy of the hash state
  logic [63:0] hash_a;
  logic [63:0] hash_b;
  logic [63:0] hash_c;
  logic [31:0] words_due;
  slot_t       word_role;

  logic [63:0] expected_hashes[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          no_idle;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic void mix_hash_state();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = hash_a;
    b = hash_b;
    c = hash_c;
    a = a - b - c; a = a ^ (c >> 43);
    b = b - c - a; b = b ^ (a << 9);
    c = c - a - b; c = c ^ (b >> 8);
    a = a - b - c; a = a ^ (c >> 38);
    b = b - c - a; b = b ^ (a << 23);
    c = c - a - b; c = c ^ (b >> 5);
    a = a - b - c; a = a ^ (c >> 35);
    b = b - c - a; b = b ^ (a << 49);
    c = c - a - b; c = c ^ (b >> 11);
    a = a - b - c; a = a ^ (c >> 12);
    b = b - c - a; b = b ^ (a << 18);
    c = c - a - b; c = c ^ (b >> 22);
    hash_a = a;
    hash_b = b;
    hash_c = c;
  endfunction

  function automatic void predict_hash(input logic op, input logic [63:0] word,
                                       input logic [31:0] count);
    if (op == OP_START) begin
      hash_a = GOLDEN;
      hash_b = GOLDEN;
      hash_c = {32'd0, count};
      words_due = count;
      word_role = SLOT_GROUP;
      if (count == 32'd0) expected_hashes.push_back(64'd0);
    end else if (words_due != 32'd0) begin
      case (word_role)
        SLOT_GROUP: begin
          if (words_due >= 32'd3) begin
            hash_c = hash_c + word;
            word_role = SLOT_B;
          end else if (words_due == 32'd2) begin
            hash_b = hash_b + word;
            word_role = SLOT_A;
          end else begin
            hash_a = hash_a + word;
            mix_hash_state();
            word_role = SLOT_GROUP;
          end
        end
        SLOT_B: begin
          hash_b = hash_b + word;
          word_role = SLOT_A;
        end
        default: begin
          hash_a = hash_a + word;
          mix_hash_state();
          word_role = SLOT_GROUP;
        end
      endcase
      words_due = words_due - 32'd1;
      if (words_due == 32'd0) expected_hashes.push_back(hash_c);
    end
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 64'd0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic op, input logic [63:0] word,
                           input logic [31:0] count);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_data_word  <= word;
    in_word_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_hash(op, word, count);
  endtask

  task automatic run_hash(input int unsigned len);
    send_item(OP_START, rand_word(), len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(OP_WORD, rand_word(), $urandom);
    end
  endtask

  task automatic test_zero_count();
    send_item(OP_START, '1, 32'd0);
    send_item(OP_START, 64'd0, 32'd0);
  endtask

  task automatic test_words_while_idle();
    send_item(OP_WORD, '1, '1);
    send_item(OP_WORD, 64'd0, 32'd0);
  endtask

  // one, two, three (no tail mix) and four words, extreme word values
  task automatic test_short_lengths();
    send_item(OP_START, 64'd0, 32'd1);
    send_item(OP_WORD, '1, 32'd0);
    send_item(OP_START, '1, 32'd2);
    send_item(OP_WORD, 64'd0, '1);
    send_item(OP_WORD, '1, 32'd0);
    send_item(OP_START, 64'd0, 32'd3);
    send_item(OP_WORD, '1, 32'd0);
    send_item(OP_WORD, '1, 32'd0);
    send_item(OP_WORD, '1, 32'd0);
    send_item(OP_START, 64'd0, 32'd4);
    send_item(OP_WORD, 64'h5555_5555_5555_5555, 32'd0);
    send_item(OP_WORD, 64'haaaa_aaaa_aaaa_aaaa, 32'd0);
    send_item(OP_WORD, 64'd0, 32'd0);
    send_item(OP_WORD, 64'h8000_0000_0000_0001, 32'd0);
  endtask

  // a start with the largest count is dropped by a later start
  task automatic test_restart();
    send_item(OP_START, 64'd0, '1);
    send_item(OP_WORD, rand_word(), 32'd0);
    send_item(OP_START, 64'd0, 32'd1);
    send_item(OP_WORD, rand_word(), 32'd0);
  endtask

  task automatic test_random_hashes();
    int unsigned items;
    int unsigned pick;
    int unsigned len;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // stray words; ignored unless a hash is still open
        repeat ($urandom_range(1, 3)) send_item(OP_WORD, rand_word(), $urandom);
      end else if (pick < 12) begin
        // abandoned hash with a full-range count
        send_item(OP_START, rand_word(), $urandom);
        len = $urandom_range(0, 4);
        for (int unsigned i = 0; i < len; i++) begin
          send_item(OP_WORD, rand_word(), $urandom);
        end
        items += len + 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) len = 0;
        else if (pick < 85) len = $urandom_range(1, 9);
        else if (pick < 97) len = $urandom_range(10, 30);
        else len = $urandom_range(31, 80);
        run_hash(len);
        items += len + 1;
      end
    end
    no_idle = 1'b0;
  endtask

  // result side: hold each result for a random number of cycles
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (out_valid !== 1'b1) @(posedge clk);
        repeat (hold - 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch("unexpected hash_value", out_hash_value, 64'd0);
      end else begin
        if (out_hash_value !== expected_hashes[0]) begin
          report_mismatch("hash_value", out_hash_value, expected_hashes[0]);
        end
        void'(expected_hashes.pop_front());
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_START;
    in_data_word = 64'd0;
    in_word_count = 32'd0;
    mismatch_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    hash_a = GOLDEN;
    hash_b = GOLDEN;
    hash_c = 64'd0;
    words_due = 32'd0;
    word_role = SLOT_GROUP;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_words_while_idle();
    test_zero_count();
    test_short_lengths();
    test_restart();
    test_words_while_idle();
    test_random_hashes();

    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
